// ----- design/pbts_pkg.sv -----
package pbts_pkg;

   localparam int NUM_PRIORITIES = 32;
   localparam int COUNT_WIDTH    = 32;
   localparam int PRIO_W         = $clog2(NUM_PRIORITIES);
   localparam int IDX_W          = $clog2(NUM_PRIORITIES + 1);

   localparam int REQ_TDATA_W    = 40;
   localparam int REQ_TUSER_W    = 3;
   localparam int RSP_TDATA_W    = 16;

   typedef enum logic [2:0] {
      CMD_TICK    = 3'd0,
      CMD_SLEEP   = 3'd1,
      CMD_READY   = 3'd2,
      CMD_UNREADY = 3'd3,
      CMD_RESCHED = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_RESCHED,
      ST_DONE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic              found;
      logic [PRIO_W-1:0] idx;
   } enc_type;

   // lowest set bit of the ready bitmap
   function automatic enc_type lowest_ready(input logic [NUM_PRIORITIES-1:0] bits);
      enc_type r;
      r.found = 1'b0;
      r.idx   = '0;
      for (int i = NUM_PRIORITIES - 1; i >= 0; i--) begin
         if (bits[i]) begin
            r.found = 1'b1;
            r.idx   = PRIO_W'(i);
         end
      end
      return r;
   endfunction

endpackage

// ----- design/priority_bitmap_task_scheduler.sv -----
// Priority bitmap task scheduler: one ready bit and one sleep countdown per priority,
// lower priority number wins.
// Request channel (req_*): command in req_tuser, priority_req and sleep length in req_tdata.
// A request is taken when req_tvalid and req_tready are both high; req_tready is high
// only while the block is idle, so one request is worked on at a time.
// Response channel (rsp_*): one response per request with best_ready, none_ready,
// switch_needed and running in rsp_tdata; it is held stable until rsp_tready.
// Work per request: a tick walks every countdown, reading, decrementing and writing
// back one entry per cycle through one shared decrementer, then reschedules; entries
// already at zero are not written back. Sleep and reschedule go through the
// reschedule step; make ready and make unready go straight to building the response.
// After the response is taken the block returns to idle before taking a new request.
// If the receiver stalls, the response waits in its output register and no new request
// is taken until it is accepted.
// Synchronous reset clears all ready bits, all countdowns and the running task; the
// countdown store is cleared at once through per-entry valid bits, so no clearing pass.
module priority_bitmap_task_scheduler (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [4:0] priority_req, [36:5] sleep length, [39:37] zero
   input  logic [pbts_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [2:0] command
   input  logic [pbts_pkg::REQ_TUSER_W-1:0]     req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [4:0] best_ready, [5] none_ready, [6] switch_needed, [11:7] running, [15:12] zero
   output logic [pbts_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);

   localparam int N  = pbts_pkg::NUM_PRIORITIES;
   localparam int CW = pbts_pkg::COUNT_WIDTH;
   localparam int PW = pbts_pkg::PRIO_W;
   localparam int IW = pbts_pkg::IDX_W;

   pbts_pkg::state_type state_ff, state_in;

   logic [N-1:0]    ready_ff, ready_in;
   logic [PW-1:0]   running_ff, running_in;
   logic            sw_ff, sw_in;
   logic [IW-1:0]   idx_ff, idx_in;
   logic            wb_en_ff, wb_en_in;
   logic [PW-1:0]   wb_idx_ff;
   logic [CW-1:0]   rd_data_ff;
   logic            rd_valid_ff;
   logic [N-1:0]    cnt_valid_ff;
   logic [pbts_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [CW-1:0]   countdown_mem [N];

   logic            wr_en;
   logic [PW-1:0]   wr_addr;
   logic [CW-1:0]   wr_data;
   logic            rd_en;
   logic            req_fire;
   logic            walk_last;
   logic [CW-1:0]   cnt_cur;
   logic [4:0]      req_prio;
   logic [CW-1:0]   req_ticks;
   pbts_pkg::cmd_type cmd;
   pbts_pkg::enc_type enc;

   assign cmd       = pbts_pkg::cmd_type'(req_tuser[2:0]);
   assign req_prio  = req_tdata[4:0];
   assign req_ticks = req_tdata[5 +: CW];
   assign req_fire  = req_tvalid && req_tready;
   assign walk_last = (idx_ff == IW'(N));
   assign enc       = pbts_pkg::lowest_ready(ready_ff);
   assign cnt_cur   = rd_valid_ff ? rd_data_ff : '0;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pbts_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (cmd)
                  pbts_pkg::CMD_TICK:    state_in = pbts_pkg::ST_WALK;
                  pbts_pkg::CMD_SLEEP:   state_in = pbts_pkg::ST_RESCHED;
                  pbts_pkg::CMD_RESCHED: state_in = pbts_pkg::ST_RESCHED;
                  default:               state_in = pbts_pkg::ST_DONE;
               endcase
            end
         end
         pbts_pkg::ST_WALK: begin
            if (walk_last && !wb_en_ff) begin
               state_in = pbts_pkg::ST_RESCHED;
            end
         end
         pbts_pkg::ST_RESCHED: state_in = pbts_pkg::ST_DONE;
         pbts_pkg::ST_DONE:    state_in = pbts_pkg::ST_RESP;
         pbts_pkg::ST_RESP: begin
            if (rsp_tready) begin
               state_in = pbts_pkg::ST_IDLE;
            end
         end
         default: state_in = pbts_pkg::ST_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      req_tready = (state_ff == pbts_pkg::ST_IDLE);
      rsp_tvalid = (state_ff == pbts_pkg::ST_RESP);
      rsp_tdata  = rsp_data_ff;
   end

   // datapath
   always_comb begin
      ready_in    = ready_ff;
      running_in  = running_ff;
      sw_in       = sw_ff;
      idx_in      = idx_ff;
      wb_en_in    = 1'b0;
      rsp_data_in = rsp_data_ff;
      wr_en       = 1'b0;
      wr_addr     = wb_idx_ff;
      wr_data     = cnt_cur - CW'(1);
      rd_en       = 1'b0;
      case (state_ff)
         pbts_pkg::ST_IDLE: begin
            if (req_fire) begin
               sw_in  = 1'b0;
               idx_in = '0;
               case (cmd)
                  pbts_pkg::CMD_SLEEP: begin
                     wr_en                = 1'b1;
                     wr_addr              = running_ff;
                     wr_data              = req_ticks;
                     ready_in[running_ff] = 1'b0;
                  end
                  pbts_pkg::CMD_READY: begin
                     if (int'(req_prio) < N) begin
                        ready_in[PW'(req_prio)] = 1'b1;
                     end
                  end
                  pbts_pkg::CMD_UNREADY: begin
                     if (int'(req_prio) < N) begin
                        ready_in[PW'(req_prio)] = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         pbts_pkg::ST_WALK: begin
            // write back the entry read last cycle
            if (wb_en_ff && (cnt_cur != '0)) begin
               wr_en = 1'b1;
               if (cnt_cur == CW'(1)) begin
                  ready_in[wb_idx_ff] = 1'b1;
               end
            end
            // read the next entry
            if (!walk_last) begin
               rd_en    = 1'b1;
               wb_en_in = 1'b1;
               idx_in   = idx_ff + IW'(1);
            end
         end
         pbts_pkg::ST_RESCHED: begin
            if (enc.found && (enc.idx != running_ff)) begin
               running_in = enc.idx;
               sw_in      = 1'b1;
            end
         end
         pbts_pkg::ST_DONE: begin
            rsp_data_in = {4'b0, 5'(running_ff), sw_ff, !enc.found, 5'(enc.idx)};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pbts_pkg::ST_IDLE;
         ready_ff     <= '0;
         running_ff   <= '0;
         sw_ff        <= 1'b0;
         idx_ff       <= '0;
         wb_en_ff     <= 1'b0;
         cnt_valid_ff <= '0;
      end else begin
         state_ff   <= state_in;
         ready_ff   <= ready_in;
         running_ff <= running_in;
         sw_ff      <= sw_in;
         idx_ff     <= idx_in;
         wb_en_ff   <= wb_en_in;
         if (wr_en) begin
            cnt_valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // countdown store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         countdown_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= countdown_mem[idx_ff[PW-1:0]];
         rd_valid_ff <= cnt_valid_ff[idx_ff[PW-1:0]];
         wb_idx_ff   <= idx_ff[PW-1:0];
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule
